// ----- rtl/rid_pkg.sv -----
// ----------------------------------------------------------------------------
// rid_pkg
// Types and codes shared by the ranged id allocator modules.
// ----------------------------------------------------------------------------
package rid_pkg;

    typedef enum logic [2:0] {
        OP_ADD_RANGE = 3'd0,
        OP_LEASE     = 3'd1,
        OP_ADD_SUB   = 3'd2,
        OP_LOOKUP    = 3'd3,
        OP_ALLOC     = 3'd4,
        OP_RELEASE   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] id_value;
        logic [31:0] upper_limit;
        logic [31:0] owner_id;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_id;
        logic [5:0]  result_size;
        logic [31:0] result_owner;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SCAN,
        S_WORD,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the input word, start index decode
        logic exec;      // perform the single-range operation
        logic scan_chk;  // evaluate scan entry
        logic word_step; // search one bit of the used word
        logic finish;    // emit result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_scan;   // lease or allocate
        logic scan_last; // scan index at last range
        logic hit;       // scan found an entry to work on
        logic stop;      // scan must stop
        logic word_done; // bit search finished
        logic word_hit;  // bit search found a free id
    } dp_stat_t;

endpackage

// ----- rtl/rid_ctrl.sv -----
// ----------------------------------------------------------------------------
// rid_ctrl
// Sequencer for the ranged id allocator.
// ----------------------------------------------------------------------------
module rid_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output rid_pkg::dp_cmd_t  cmd,
    input  rid_pkg::dp_stat_t stat
);

    rid_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rid_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rid_pkg::S_IDLE:
                if (start) state_next = rid_pkg::S_READ;
            rid_pkg::S_READ:
                state_next = stat.is_scan ? rid_pkg::S_SCAN : rid_pkg::S_EXEC;
            rid_pkg::S_EXEC:
                state_next = rid_pkg::S_DONE;
            rid_pkg::S_SCAN:
                if (stat.stop)
                    state_next = rid_pkg::S_DONE;
                else if (stat.hit)
                    state_next = rid_pkg::S_WORD;
                else if (stat.scan_last)
                    state_next = rid_pkg::S_DONE;
                else
                    state_next = rid_pkg::S_SCAN;
            rid_pkg::S_WORD:
                if (!stat.word_done)
                    state_next = rid_pkg::S_WORD;
                else if (stat.word_hit || stat.scan_last)
                    state_next = rid_pkg::S_DONE;
                else
                    state_next = rid_pkg::S_SCAN;
            rid_pkg::S_DONE:
                state_next = rid_pkg::S_IDLE;
            default:
                state_next = rid_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        busy     = (state_reg != rid_pkg::S_IDLE);
        case (state_reg)
            rid_pkg::S_IDLE: cmd.load      = start;
            rid_pkg::S_EXEC: cmd.exec      = 1'b1;
            rid_pkg::S_SCAN: cmd.scan_chk  = 1'b1;
            rid_pkg::S_WORD: cmd.word_step = 1'b1;
            rid_pkg::S_DONE: cmd.finish    = 1'b1;
            default:         cmd           = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rid_pkg::S_IDLE) |-> !busy)
        else $error("busy in idle");
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rid_pkg::S_DONE) |=> (state_reg == rid_pkg::S_IDLE))
        else $error("done did not return to idle");
    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rid_pkg::S_IDLE && start) |=> (state_reg == rid_pkg::S_READ))
        else $error("start not taken");
`endif

endmodule

// ----- rtl/rid_dp.sv -----
// ----------------------------------------------------------------------------
// rid_dp
// Range table, bitmaps, sub-owner memory and the operation datapath.
// ----------------------------------------------------------------------------
module rid_dp #(
    parameter int IDS_PER_RANGE = 32,
    parameter int RANGE_COUNT   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        self_id,
    input  rid_pkg::in_word_t  in_word,
    input  rid_pkg::dp_cmd_t   cmd,
    output rid_pkg::dp_stat_t  stat,
    output logic               done,
    output rid_pkg::out_word_t out_word
);

    localparam int PW = $clog2(IDS_PER_RANGE);
    localparam int RW = $clog2(RANGE_COUNT);
    localparam int SW = RW + PW;

    // range table storage
    logic [RANGE_COUNT-1:0]   valid_reg;
    logic [31:0]              owner_mem [RANGE_COUNT];
    logic [IDS_PER_RANGE-1:0] used_mem  [RANGE_COUNT];
    logic [IDS_PER_RANGE-1:0] subv_mem  [RANGE_COUNT];
    logic [31:0]              sub_mem   [RANGE_COUNT*IDS_PER_RANGE];

    logic [2:0]  op_reg;
    logic [31:0] idv_reg, lim_reg, own_reg, cur_reg;
    logic [31:0] idm1;
    logic        oor_reg;
    logic [RW-1:0] r_reg;
    logic [PW-1:0] pos_reg, bit_reg;
    logic [31:0] owner_rd;
    logic [IDS_PER_RANGE-1:0] used_rd, subv_rd;
    logic [31:0] sub_rd;
    logic        rd_valid_reg;
    logic [1:0]  st_reg;
    logic [31:0] rid_reg, rown_reg;
    logic [5:0]  rsz_reg;
    logic        done_reg;

    // range index and position of the id: (id-1)/IDS and (id-1)%IDS
    logic [31:0] q32;
    always_comb
    begin
        idm1 = in_word.id_value - 32'd1;
        q32  = idm1 >> PW;
    end

    logic [31:0] base_k;
    assign base_k = ({{(32-RW){1'b0}}, r_reg} << PW) + 32'd1;

    logic scan_op;
    assign scan_op = (op_reg == rid_pkg::OP_LEASE) || (op_reg == rid_pkg::OP_ALLOC);

    // lease: first invalid range; found by priority over the valid bits
    logic          free_any;
    logic [RW-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = RANGE_COUNT - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_any = 1'b1;
                free_idx = RW'(k);
            end
        end
    end

    // allocate scan decisions on the entry read last cycle
    logic        own_ok, lim_stop, past_end;
    logic [32:0] end_k;
    always_comb
    begin
        own_ok   = rd_valid_reg && (owner_rd == self_id);
        lim_stop = (lim_reg != 32'd0) && (cur_reg >= lim_reg);
        end_k    = {1'b0, base_k} + 33'(IDS_PER_RANGE);
        past_end = ({1'b0, cur_reg} >= end_k);
    end

    logic alloc_hit;
    assign alloc_hit = own_ok && !lim_stop && !past_end;

    always_comb
    begin
        stat.is_scan   = scan_op;
        stat.scan_last = (r_reg == RW'(RANGE_COUNT - 1));
        stat.stop      = (op_reg == rid_pkg::OP_LEASE) || (own_ok && lim_stop);
        stat.hit       = alloc_hit;
        stat.word_done = !used_rd[bit_reg] || (bit_reg == PW'(IDS_PER_RANGE - 1));
        stat.word_hit  = !used_rd[bit_reg];
    end

    // read the next range ahead when the scan moves on, so its data is ready
    logic          scan_adv;
    logic [RW-1:0] rd_addr;
    always_comb
    begin
        scan_adv = 1'b0;
        if (cmd.scan_chk && op_reg == rid_pkg::OP_ALLOC && !alloc_hit &&
            !(own_ok && lim_stop) && !stat.scan_last)
            scan_adv = 1'b1;
        if (cmd.word_step && used_rd[bit_reg] &&
            bit_reg == PW'(IDS_PER_RANGE - 1) && !stat.scan_last)
            scan_adv = 1'b1;
        rd_addr = scan_adv ? r_reg + RW'(1) : r_reg;
    end

    always_ff @(posedge clk)
    begin
        owner_rd <= owner_mem[rd_addr];
        used_rd  <= used_mem[rd_addr];
        subv_rd  <= subv_mem[rd_addr];
        sub_rd   <= sub_mem[{r_reg, pos_reg}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            done_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg     <= cmd.finish;
            rd_valid_reg <= valid_reg[rd_addr];
            if (cmd.exec && !oor_reg)
            begin
                if (op_reg == rid_pkg::OP_ADD_RANGE || op_reg == rid_pkg::OP_ADD_SUB)
                    valid_reg[r_reg] <= 1'b1;
            end
            if (cmd.scan_chk && op_reg == rid_pkg::OP_LEASE && free_any)
                valid_reg[free_idx] <= 1'b1;
        end
    end

    // memory writes and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_word.operation;
            idv_reg <= in_word.id_value;
            lim_reg <= in_word.upper_limit;
            own_reg <= in_word.owner_id;
            cur_reg <= in_word.id_value;
            oor_reg <= (q32 >= 32'(RANGE_COUNT)) &&
                       (in_word.operation inside {rid_pkg::OP_ADD_RANGE, rid_pkg::OP_ADD_SUB,
                                                  rid_pkg::OP_LOOKUP, rid_pkg::OP_RELEASE});
            pos_reg <= idm1[PW-1:0];
            r_reg   <= (in_word.operation == rid_pkg::OP_ALLOC) ? '0 : q32[RW-1:0];
            st_reg  <= rid_pkg::ST_OK;
            rid_reg <= '0;
            rsz_reg <= '0;
            rown_reg <= '0;
        end
        if (cmd.exec)
        begin
            if (oor_reg)
                st_reg <= rid_pkg::ST_RANGE;
            else
            begin
                case (op_reg)
                    rid_pkg::OP_ADD_RANGE:
                    begin
                        owner_mem[r_reg] <= own_reg;
                        if (!rd_valid_reg)
                        begin
                            used_mem[r_reg] <= '0;
                            subv_mem[r_reg] <= '0;
                        end
                    end
                    rid_pkg::OP_ADD_SUB:
                    begin
                        if (!rd_valid_reg)
                        begin
                            owner_mem[r_reg] <= '0;
                            used_mem[r_reg]  <= '0;
                            subv_mem[r_reg]  <= IDS_PER_RANGE'(1) << pos_reg;
                        end
                        else
                            subv_mem[r_reg] <= subv_rd | (IDS_PER_RANGE'(1) << pos_reg);
                        sub_mem[{r_reg, pos_reg}] <= own_reg;
                    end
                    rid_pkg::OP_LOOKUP:
                    begin
                        if (!rd_valid_reg)
                            st_reg <= rid_pkg::ST_NOTFOUND;
                        else if (subv_rd[pos_reg])
                        begin
                            if (sub_rd == 32'd0)
                                st_reg <= rid_pkg::ST_NOTFOUND;
                            else
                            begin
                                rid_reg  <= idv_reg;
                                rsz_reg  <= 6'd1;
                                rown_reg <= sub_rd;
                            end
                        end
                        else if (owner_rd == 32'd0)
                            st_reg <= rid_pkg::ST_NOTFOUND;
                        else
                        begin
                            rid_reg  <= base_k;
                            rsz_reg  <= 6'(IDS_PER_RANGE);
                            rown_reg <= owner_rd;
                        end
                    end
                    rid_pkg::OP_RELEASE:
                    begin
                        if (!rd_valid_reg)
                            st_reg <= rid_pkg::ST_NOTFOUND;
                        else
                        begin
                            subv_mem[r_reg] <= subv_rd & ~(IDS_PER_RANGE'(1) << pos_reg);
                            used_mem[r_reg] <= used_rd & ~(IDS_PER_RANGE'(1) << pos_reg);
                        end
                    end
                    default:
                        st_reg <= rid_pkg::ST_NOTFOUND;
                endcase
            end
        end
        if (cmd.scan_chk)
        begin
            if (op_reg == rid_pkg::OP_LEASE)
            begin
                if (free_any)
                begin
                    owner_mem[free_idx] <= own_reg;
                    used_mem[free_idx]  <= '0;
                    subv_mem[free_idx]  <= '0;
                    rid_reg <= ({{(32-RW){1'b0}}, free_idx} << PW) + 32'd1;
                end
                else
                    st_reg <= rid_pkg::ST_FULL;
            end
            else if (alloc_hit)
            begin
                if (cur_reg < base_k)
                begin
                    cur_reg <= base_k;
                    bit_reg <= '0;
                end
                else
                    bit_reg <= PW'(cur_reg - base_k);
            end
            else if ((own_ok && lim_stop) || stat.scan_last)
                st_reg <= rid_pkg::ST_FULL;
            else
                r_reg <= r_reg + RW'(1);
        end
        if (cmd.word_step)
        begin
            if (!used_rd[bit_reg])
            begin
                used_mem[r_reg] <= used_rd | (IDS_PER_RANGE'(1) << bit_reg);
                rid_reg <= base_k + 32'(bit_reg);
            end
            else if (bit_reg == PW'(IDS_PER_RANGE - 1))
            begin
                // range exhausted: continue scan at next range unless last
                if (stat.scan_last)
                    st_reg <= rid_pkg::ST_FULL;
                else
                    r_reg <= r_reg + RW'(1);
            end
            else
                bit_reg <= bit_reg + PW'(1);
        end
    end

    assign done = done_reg;
    always_comb
    begin
        out_word.status       = st_reg;
        out_word.result_id    = rid_reg;
        out_word.result_size  = rsz_reg;
        out_word.result_owner = rown_reg;
    end

`ifndef SYNTHESIS
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_word.status == rid_pkg::ST_FULL) |-> (out_word.result_id == 32'd0))
        else $error("full result carries an id");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_size_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done && op_reg != rid_pkg::OP_LOOKUP) |-> (out_word.result_size == 6'd0))
        else $error("size set outside lookup");
`endif

endmodule

// ----- rtl/ranged_id_allocator.sv -----
// ----------------------------------------------------------------------------
// ranged_id_allocator
// Range table id allocator: add, lease, sub-owner, lookup, allocate, release.
// ----------------------------------------------------------------------------
// One word is taken when start is high and busy is low; one result word
// follows, marked by done for a single cycle, and must be taken then.
// Add range, sub-owner, lookup and release go through the read, exec and
// done states; lease goes through read, scan and done. Allocate walks the
// range table one range per cycle and the used bitmap of each candidate
// range one bit per cycle, moving on to the next range when a bitmap is full.
// self_id is written through cfg_we/cfg_data; the user must do so only while idle, the block does not enforce it.
module ranged_id_allocator #(
    parameter int IDS_PER_RANGE = 32,
    parameter int RANGE_COUNT   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rid_pkg::in_word_t  in_word,
    output logic               done,
    output rid_pkg::out_word_t out_word,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data
);

    logic [31:0]       self_id_reg;
    rid_pkg::dp_cmd_t  cmd;
    rid_pkg::dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            self_id_reg <= '0;
        else if (cfg_we)
            self_id_reg <= cfg_data;
    end

    rid_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    rid_dp #(
        .IDS_PER_RANGE (IDS_PER_RANGE),
        .RANGE_COUNT   (RANGE_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .self_id  (self_id_reg),
        .in_word  (in_word),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .out_word (out_word)
    );

endmodule

// ----- test/tb_ranged_id_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ranged_id_allocator
// Drives add, lease, sub-owner, lookup, allocate, release and unused-code words
// into the id allocator. Expected results come from a behavioral copy of the
// range table, and every result word is compared against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_ranged_id_allocator;

    localparam int IPR = 32;
    localparam int NRANGE = 64;
    localparam int STALL_LIMIT = 20000;

    class id_table_scoreboard;
        bit          valid_q [NRANGE];
        logic [31:0] owner_q [NRANGE];
        logic [31:0] used_q [NRANGE];
        logic [31:0] subv_q [NRANGE];
        logic [31:0] subown_q [NRANGE*IPR];
        logic [31:0] self_q;
        rid_pkg::out_word_t pending[$];
        int          mismatches;

        function void clear();
            foreach (valid_q[i]) valid_q[i] = 0;
            self_q = 0;
        endfunction

        function void put_range(int r, logic [31:0] own);
            if (!valid_q[r]) begin
                used_q[r] = 0;
                subv_q[r] = 0;
            end
            valid_q[r] = 1;
            owner_q[r] = own;
        endfunction

        function void note_word(rid_pkg::in_word_t w);
            rid_pkg::out_word_t e;
            logic [31:0] r, pos, cur, b, o;
            bit          found;
            e = '0;
            e.status = rid_pkg::ST_OK;
            r = (w.id_value - 32'd1) / IPR;
            pos = (w.id_value - 32'd1) % IPR;
            if ((w.operation == rid_pkg::OP_ADD_RANGE || w.operation == rid_pkg::OP_ADD_SUB ||
                 w.operation == rid_pkg::OP_LOOKUP || w.operation == rid_pkg::OP_RELEASE) &&
                r >= NRANGE)
                e.status = rid_pkg::ST_RANGE;
            else case (w.operation)
                rid_pkg::OP_ADD_RANGE: put_range(r, w.owner_id);
                rid_pkg::OP_LEASE:
                begin
                    e.status = rid_pkg::ST_FULL;
                    for (int k = 0; k < NRANGE; k++)
                        if (!valid_q[k]) begin
                            put_range(k, w.owner_id);
                            e.result_id = k*IPR + 1;
                            e.status = rid_pkg::ST_OK;
                            break;
                        end
                end
                rid_pkg::OP_ADD_SUB:
                begin
                    if (!valid_q[r]) put_range(r, 0);
                    subv_q[r][pos] = 1'b1;
                    subown_q[r*IPR+pos] = w.owner_id;
                end
                rid_pkg::OP_LOOKUP:
                begin
                    if (!valid_q[r]) e.status = rid_pkg::ST_NOTFOUND;
                    else begin
                        b = r*IPR + 1;
                        e.result_size = 6'(IPR);
                        o = owner_q[r];
                        if (subv_q[r][pos]) begin
                            b = w.id_value;
                            e.result_size = 6'd1;
                            o = subown_q[r*IPR+pos];
                        end
                        if (o == 0) begin
                            e.status = rid_pkg::ST_NOTFOUND;
                            e.result_size = 6'd0;
                        end else begin
                            e.result_id = b;
                            e.result_owner = o;
                        end
                    end
                end
                rid_pkg::OP_ALLOC:
                begin
                    cur = w.id_value;
                    found = 0;
                    for (int k = 0; k < NRANGE && !found; k++) begin
                        if (!valid_q[k] || owner_q[k] != self_q) continue;
                        if (w.upper_limit != 0 && cur >= w.upper_limit) break;
                        b = k*IPR + 1;
                        if ({32'd0, cur} >= {32'd0, b} + IPR) continue;
                        if (cur < b) cur = b;
                        for (int p = cur - b; p < IPR; p++)
                            if (!used_q[k][p]) begin
                                used_q[k][p] = 1'b1;
                                e.result_id = b + p;
                                found = 1;
                                break;
                            end
                    end
                    if (!found) e.status = rid_pkg::ST_FULL;
                end
                rid_pkg::OP_RELEASE:
                begin
                    if (!valid_q[r]) e.status = rid_pkg::ST_NOTFOUND;
                    else begin
                        subv_q[r][pos] = 1'b0;
                        used_q[r][pos] = 1'b0;
                    end
                end
                default: e.status = rid_pkg::ST_NOTFOUND;
            endcase
            pending.push_back(e);
        endfunction

        function void check_word(rid_pkg::out_word_t got);
            rid_pkg::out_word_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st=%0d id=%h sz=%0d own=%h %s",
                             e.status, e.result_id, e.result_size, e.result_owner,
                             $sformatf("got st=%0d id=%h sz=%0d own=%h",
                                       got.status, got.result_id, got.result_size,
                                       got.result_owner));
            end
        endfunction
    endclass

    logic      clk, rst_n, start, cfg_we;
    logic      busy, done;
    rid_pkg::in_word_t  in_word;
    rid_pkg::out_word_t out_word;
    logic [31:0] cfg_data;
    id_table_scoreboard sb;
    int  quiet_cycles;
    bit  no_idle;

    ranged_id_allocator u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
        .done(done), .out_word(out_word), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_word(out_word);
        if (rst_n && (done || (start && !busy))) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(logic [2:0] op, logic [31:0] idv, logic [31:0] lim,
                             logic [31:0] own);
        rid_pkg::in_word_t w;
        w.operation = op;
        w.id_value = idv;
        w.upper_limit = lim;
        w.owner_id = own;
        while (!no_idle && $urandom_range(99) < 37) @(posedge clk);
        start <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_word(w);
        start <= 1'b0;
        // the block stays busy after taking a word until it is back in idle
        @(posedge clk);
    endtask

    task automatic set_self(logic [31:0] v);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (110) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.self_q = v;
    endtask

    function automatic logic [31:0] pick_id();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 0;
            2: return NRANGE*IPR + $urandom_range(3);
            default: return $urandom_range(NRANGE*IPR, 1);
        endcase
    endfunction

    task automatic random_phase(int n, logic [31:0] self);
        logic [2:0] op;
        logic [31:0] own;
        for (int i = 0; i < n; i++) begin
            no_idle = (i >= n/3 && i < n/2);
            op = $urandom_range(99) < 3 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            own = $urandom_range(3) == 0 ? $urandom : ($urandom_range(1) ? self : 0);
            send_word(op, pick_id(), $urandom_range(2) == 0 ? 0 : $urandom_range(2100),
                      own);
        end
        no_idle = 0;
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        start = 0;
        cfg_we = 0;
        cfg_data = 0;
        in_word = '0;
        quiet_cycles = 0;
        no_idle = 0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: self_id 0, sub-owner on a missing range counts as owned
        send_word(rid_pkg::OP_LOOKUP, 1, 0, 0);
        send_word(rid_pkg::OP_ADD_SUB, 5, 0, 0);
        send_word(rid_pkg::OP_LOOKUP, 5, 0, 0);
        send_word(rid_pkg::OP_ALLOC, 0, 0, 0);
        send_word(rid_pkg::OP_ALLOC, 1, 0, 0);
        send_word(rid_pkg::OP_ADD_RANGE, 0, 0, 7);
        send_word(rid_pkg::OP_ADD_RANGE, 32'hFFFF_FFFF, 0, 7);
        send_word(rid_pkg::OP_ADD_RANGE, NRANGE*IPR, 0, 32'hFFFF_FFFF);
        send_word(rid_pkg::OP_ADD_RANGE, NRANGE*IPR + 1, 0, 1);
        send_word(rid_pkg::OP_LOOKUP, NRANGE*IPR - 3, 0, 0);
        send_word(rid_pkg::OP_ADD_SUB, 40, 0, 32'h1234_5678);
        send_word(rid_pkg::OP_LOOKUP, 40, 0, 0);
        send_word(rid_pkg::OP_RELEASE, 40, 0, 0);
        send_word(rid_pkg::OP_RELEASE, 200, 0, 0);
        send_word(rid_pkg::OP_LEASE, 0, 0, 9);
        send_word(3'd6, 1, 0, 0);
        send_word(3'd7, 1, 0, 0);
        set_self(32'hFFFF_FFFF);
        send_word(rid_pkg::OP_LEASE, 0, 0, 32'hFFFF_FFFF);
        send_word(rid_pkg::OP_ALLOC, 1, 0, 0);
        send_word(rid_pkg::OP_ALLOC, 1, 1, 0);
        send_word(rid_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        for (int i = 0; i < NRANGE; i++)
            send_word(rid_pkg::OP_LEASE, 0, 0, 32'hFFFF_FFFF);

        set_self(32'h0000_0003);
        random_phase(220, 32'h3);
        set_self(0);
        random_phase(220, 0);
        set_self($urandom);
        random_phase(220, sb.self_q);

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/rid_pkg.sv
rtl/rid_ctrl.sv
rtl/rid_dp.sv
rtl/ranged_id_allocator.sv
test/tb_ranged_id_allocator.sv
